[sv/srdp_pkg.sv]
// srdp_pkg: shared constants, codes and types of the sparse record parser
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package srdp_pkg;

    localparam int MAX_DIMENSION = 1024;
    localparam int ADDR_W        = $clog2(MAX_DIMENSION);
    localparam int SLOT_W        = 10;
    localparam int WORD_W        = 32;
    localparam int DIM_W         = 11;
    localparam int KIND_W        = 2;

    // record epoch tags kept next to each dense value
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

    localparam logic [KIND_W-1:0] KIND_LABEL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

    typedef enum logic [5:0] {
        PH_HDR0   = 6'b000001,
        PH_HDR1   = 6'b000010,
        PH_FCOUNT = 6'b000100,
        PH_LCOUNT = 6'b001000,
        PH_PAIRS  = 6'b010000,
        PH_LABELS = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        POS_ID_LO = 3'b001,
        POS_ID_HI = 3'b010,
        POS_VALUE = 3'b100
    } pos_t;

    // one command from the front to the back
    typedef struct packed {
        logic                 clear;
        logic                 write;
        logic                 read;
        logic                 emit;
        logic [KIND_W-1:0]    kind;
        logic [ADDR_W-1:0]    addr;
        logic [WORD_W-1:0]    value;
        logic [SLOT_W-1:0]    slot;
        logic                 last;
        logic                 bad;
        logic [EPOCH_W-1:0]   epoch;
        logic                 in_store;
    } cmd_t;

    typedef struct packed {
        logic sweeping;
    } back_status_t;

endpackage

`default_nettype wire

[sv/srdp_front.sv]
// srdp_front: accepts input beats, tracks the record parse and issues commands
// depends on srdp_pkg
`timescale 1ns / 1ps
`default_nettype none

module srdp_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_mode,
    input  wire logic [31:0]                  s_data_word,
    input  wire logic [9:0]                   s_read_slot,
    input  wire logic                         cfg_valid,
    input  wire logic [10:0]                  cfg_dense_dimension,
    input  wire logic                         q_full,
    input  wire srdp_pkg::back_status_t       back_status,
    output logic                              q_push,
    output srdp_pkg::cmd_t                    q_cmd
);
    import srdp_pkg::*;

    phase_t              phase_reg, phase_next;
    pos_t                pos_reg, pos_next;
    logic [WORD_W-1:0]   features_reg, features_next;
    logic [WORD_W-1:0]   labels_reg, labels_next;
    logic [WORD_W-1:0]   pending_reg, pending_next;
    logic                bad_reg, bad_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [DIM_W-1:0]    dim_reg;
    logic [WORD_W-1:0]   eff_dim;
    logic                accept;

    assign s_ready = !q_full && !back_status.sweeping;
    assign accept  = s_valid && s_ready;

    assign eff_dim = (WORD_W'(dim_reg) > WORD_W'(MAX_DIMENSION)) ?
                     WORD_W'(MAX_DIMENSION) : WORD_W'(dim_reg);

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        features_next = features_reg;
        labels_next   = labels_reg;
        pending_next  = pending_reg;
        bad_next      = bad_reg;
        epoch_next    = epoch_reg;
        q_push        = 1'b0;
        q_cmd         = '0;
        q_cmd.epoch   = epoch_reg;
        q_cmd.bad     = bad_reg;
        if (accept) begin
            if (s_mode) begin
                q_push         = 1'b1;
                q_cmd.read     = 1'b1;
                q_cmd.emit     = 1'b1;
                q_cmd.kind     = KIND_READ;
                q_cmd.slot     = s_read_slot;
                q_cmd.addr     = ADDR_W'(s_read_slot);
                q_cmd.in_store = WORD_W'(s_read_slot) < WORD_W'(MAX_DIMENSION);
            end else begin
                case (phase_reg)
                    PH_HDR0: begin
                        bad_next   = 1'b0;
                        phase_next = PH_HDR1;
                        // tag wrap: reset the tags so no stale entry matches again
                        if (epoch_reg == EPOCH_MAX) begin
                            epoch_next  = EPOCH_FIRST;
                            q_push      = 1'b1;
                            q_cmd.clear = 1'b1;
                        end else begin
                            epoch_next = epoch_reg + EPOCH_W'(1);
                        end
                    end
                    PH_HDR1: begin
                        phase_next = PH_FCOUNT;
                    end
                    PH_FCOUNT: begin
                        features_next = s_data_word;
                        phase_next    = PH_LCOUNT;
                    end
                    PH_LCOUNT: begin
                        labels_next = s_data_word;
                        pos_next    = POS_ID_LO;
                        if (features_reg == '0) begin
                            if (s_data_word == '0) begin
                                phase_next = PH_HDR0;
                                q_push     = 1'b1;
                                q_cmd.emit = 1'b1;
                                q_cmd.kind = KIND_DONE;
                            end else begin
                                phase_next = PH_LABELS;
                            end
                        end else begin
                            phase_next = PH_PAIRS;
                        end
                    end
                    PH_PAIRS: begin
                        case (pos_reg)
                            POS_ID_LO: begin
                                pending_next = s_data_word;
                                pos_next     = POS_ID_HI;
                            end
                            POS_ID_HI: begin
                                pos_next = POS_VALUE;
                            end
                            POS_VALUE: begin
                                pos_next = POS_ID_LO;
                                if (pending_reg < eff_dim) begin
                                    q_push      = 1'b1;
                                    q_cmd.write = 1'b1;
                                    q_cmd.addr  = ADDR_W'(pending_reg);
                                    q_cmd.value = s_data_word;
                                end else begin
                                    bad_next = 1'b1;
                                end
                                features_next = features_reg - WORD_W'(1);
                                // last feature: close with a done if the record has no labels, else go on to the labels
                                if (features_reg == WORD_W'(1)) begin
                                    if (labels_reg == '0) begin
                                        phase_next = PH_HDR0;
                                        q_push     = 1'b1;
                                        q_cmd.emit = 1'b1;
                                        q_cmd.kind = KIND_DONE;
                                        q_cmd.bad  = bad_next;
                                    end else begin
                                        phase_next = PH_LABELS;
                                    end
                                end
                            end
                            default: begin
                                pos_next = POS_ID_LO;
                            end
                        endcase
                    end
                    PH_LABELS: begin
                        labels_next = labels_reg - WORD_W'(1);
                        q_push      = 1'b1;
                        q_cmd.emit  = 1'b1;
                        q_cmd.kind  = KIND_LABEL;
                        q_cmd.value = s_data_word;
                        if (labels_reg == WORD_W'(1)) begin
                            q_cmd.last = 1'b1;
                            phase_next = PH_HDR0;
                        end
                    end
                    default: begin
                        phase_next = PH_HDR0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HDR0;
            pos_reg      <= POS_ID_LO;
            features_reg <= '0;
            labels_reg   <= '0;
            pending_reg  <= '0;
            bad_reg      <= 1'b0;
            epoch_reg    <= EPOCH_FIRST;
            dim_reg      <= DIM_RESET;
        end else begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            features_reg <= features_next;
            labels_reg   <= labels_next;
            pending_reg  <= pending_next;
            bad_reg      <= bad_next;
            epoch_reg    <= epoch_next;
            if (cfg_valid) begin
                dim_reg <= cfg_dense_dimension;
            end
        end
    end

endmodule

`default_nettype wire

[sv/srdp_cmd_fifo.sv]
// srdp_cmd_fifo: two-entry command queue between front and back
// depends on srdp_pkg
`timescale 1ns / 1ps
`default_nettype none

module srdp_cmd_fifo (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire srdp_pkg::cmd_t   push_cmd,
    input  wire logic             pop,
    output srdp_pkg::cmd_t        head,
    output logic                  empty,
    output logic                  full
);
    import srdp_pkg::*;

    cmd_t        entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[sv/srdp_back.sv]
// srdp_back: dense store with epoch tags, tag sweep, read stage and output register
// depends on srdp_pkg
`timescale 1ns / 1ps
`default_nettype none

module srdp_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire srdp_pkg::cmd_t    head,
    input  wire logic              q_empty,
    output logic                   q_pop,
    output srdp_pkg::back_status_t back_status,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_kind,
    output logic [31:0]            m_value_bits,
    output logic [9:0]             m_slot,
    output logic                   m_last_label,
    output logic                   m_bad_id_seen
);
    import srdp_pkg::*;

    localparam int MEM_W = EPOCH_W + WORD_W;

    logic [MEM_W-1:0]   mem [MAX_DIMENSION];
    logic [MEM_W-1:0]   rd_data_reg;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    logic [MEM_W-1:0]   mem_wdata;

    logic               sweep_reg, sweep_next;
    logic [ADDR_W-1:0]  sweep_cnt_reg, sweep_cnt_next;

    logic               a_valid_reg, a_valid_next;
    cmd_t               a_cmd_reg;
    logic               a_adv;
    logic               hit;
    logic [WORD_W-1:0]  a_value;

    logic               out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [WORD_W-1:0]  out_value_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic               out_last_reg;
    logic               out_bad_reg;

    assign back_status.sweeping = sweep_reg;

    assign a_adv = a_valid_reg && (!out_valid_reg || m_ready);
    assign q_pop = !q_empty && !sweep_reg && (!a_valid_reg || a_adv);

    // sweep owns the port; otherwise the queue head drives it
    assign mem_addr  = sweep_reg ? sweep_cnt_reg : head.addr;
    assign mem_we    = sweep_reg || (q_pop && head.write);
    assign mem_re    = q_pop && head.read;
    assign mem_wdata = sweep_reg ? '0 : {head.epoch, head.value};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_comb begin
        sweep_next     = sweep_reg;
        sweep_cnt_next = sweep_cnt_reg;
        if (sweep_reg) begin
            sweep_cnt_next = sweep_cnt_reg + ADDR_W'(1);
            if (sweep_cnt_reg == ADDR_W'(MAX_DIMENSION - 1)) begin
                sweep_next = 1'b0;
            end
        end else if (q_pop && head.clear) begin
            sweep_next     = 1'b1;
            sweep_cnt_next = '0;
        end
    end

    always_comb begin
        if (q_pop) begin
            a_valid_next = head.emit;
        end else if (a_adv) begin
            a_valid_next = 1'b0;
        end else begin
            a_valid_next = a_valid_reg;
        end
        out_valid_next = a_adv ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    assign hit = a_cmd_reg.in_store &&
                 (rd_data_reg[MEM_W-1:WORD_W] == a_cmd_reg.epoch);

    always_comb begin
        case (a_cmd_reg.kind)
            KIND_READ:  a_value = hit ? rd_data_reg[WORD_W-1:0] : '0;
            KIND_LABEL: a_value = a_cmd_reg.value;
            default:    a_value = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            a_cmd_reg <= head;
        end
        if (a_adv) begin
            out_kind_reg  <= a_cmd_reg.kind;
            out_value_reg <= a_value;
            out_slot_reg  <= (a_cmd_reg.kind == KIND_READ) ? a_cmd_reg.slot : '0;
            out_last_reg  <= a_cmd_reg.last;
            out_bad_reg   <= a_cmd_reg.bad;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            sweep_reg     <= sweep_next;
            sweep_cnt_reg <= sweep_cnt_next;
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_kind        = out_kind_reg;
    assign m_value_bits  = out_value_reg;
    assign m_slot        = out_slot_reg;
    assign m_last_label  = out_last_reg;
    assign m_bad_id_seen = out_bad_reg;

endmodule

`default_nettype wire

[sv/sparse_record_to_dense_parser.sv]
// sparse_record_to_dense_parser: record words in, labels, done marks and slot reads out
// results pass the command queue, the read stage and the output register; one beat per cycle while s_ready is high
// input is held off while the command queue is full or the single store port is busy sweeping
// reset: tag sweep of all 1024 dense store entries with s_ready low; the same sweep
// runs once the record tag wraps, every 255 records, after queued work drains
// depends on srdp_pkg, srdp_front, srdp_cmd_fifo, srdp_back
`timescale 1ns / 1ps
`default_nettype none

module sparse_record_to_dense_parser (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic         s_mode,
    input  wire logic [31:0]  s_data_word,
    input  wire logic [9:0]   s_read_slot,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [1:0]        m_kind,
    output logic [31:0]       m_value_bits,
    output logic [9:0]        m_slot,
    output logic              m_last_label,
    output logic              m_bad_id_seen,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [10:0]  cfg_dense_dimension
);
    import srdp_pkg::*;

    cmd_t          push_cmd;
    cmd_t          head;
    logic          q_push, q_pop, q_empty, q_full;
    back_status_t  back_status;

    assign cfg_ready = 1'b1;

    srdp_front u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_data_word         (s_data_word),
        .s_read_slot         (s_read_slot),
        .cfg_valid           (cfg_valid),
        .cfg_dense_dimension (cfg_dense_dimension),
        .q_full              (q_full),
        .back_status         (back_status),
        .q_push              (q_push),
        .q_cmd               (push_cmd)
    );

    srdp_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    srdp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .back_status   (back_status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_value_bits  (m_value_bits),
        .m_slot        (m_slot),
        .m_last_label  (m_last_label),
        .m_bad_id_seen (m_bad_id_seen)
    );

endmodule

`default_nettype wire

[dv/sparse_record_to_dense_parser_tb.sv]
// sparse_record_to_dense_parser_tb: self-checking bench for the sparse record parser
// record beats and slot reads go through a behavioral parser; results are matched in order
// depends on srdp_pkg and sparse_record_to_dense_parser
`timescale 1ns / 1ps

module sparse_record_to_dense_parser_tb;

    import srdp_pkg::*;

    localparam logic MODE_WORD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam int unsigned RANDOM_BEATS   = 1080;
    localparam int unsigned DIM_SETTINGS   = 6;
    localparam int unsigned SETTLE_CYCLES  = 10;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned WATCHDOG_LIMIT = 6000;
    localparam int unsigned RX_HOLD_AFTER  = 80;
    localparam int unsigned RX_HOLD_CYCLES = 400;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] value;
        logic [SLOT_W-1:0] slot;
        logic              last;
        logic              bad;
    } result_t;

    typedef struct {
        logic              mode;
        logic [WORD_W-1:0] word;
        logic [SLOT_W-1:0] rslot;
        bit                fixed;      // result typed into the directed table
        result_t           fixed_res;
    } beat_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_mode = MODE_WORD;
    logic [31:0]       s_data_word = '0;
    logic [9:0]        s_read_slot = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_kind;
    logic [31:0]       m_value_bits;
    logic [9:0]        m_slot;
    logic              m_last_label;
    logic              m_bad_id_seen;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [10:0]       cfg_dense_dimension = DIM_RESET;

    sparse_record_to_dense_parser u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_data_word         (s_data_word),
        .s_read_slot         (s_read_slot),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_kind              (m_kind),
        .m_value_bits        (m_value_bits),
        .m_slot              (m_slot),
        .m_last_label        (m_last_label),
        .m_bad_id_seen       (m_bad_id_seen),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_dense_dimension (cfg_dense_dimension)
    );

    always #1 aclk = ~aclk;

    // behavioral parser state
    logic [DIM_W-1:0]  dim_reg = DIM_RESET;
    phase_t            parse_ph = PH_HDR0;
    pos_t              pair_pos = POS_ID_LO;
    logic [31:0]       feature_left = '0;
    logic [31:0]       label_left = '0;
    logic [31:0]       id_pending = '0;
    logic              bad_flag = 1'b0;
    logic [WORD_W-1:0] dense_mem [MAX_DIMENSION];
    bit                slot_live [MAX_DIMENSION];

    result_t     results_due [$];
    beat_t       feed_q [$];
    beat_t       beat_on_bus;
    bit          slot_written [MAX_DIMENSION];
    logic [9:0]  written_list [$];

    int unsigned mismatches = 0;
    int unsigned beats_taken = 0;
    int unsigned slot_reads = 0;
    int unsigned records_seen = 0;
    int unsigned results_checked = 0;
    int unsigned settings_used = 0;
    int unsigned stall_cycles = 0;
    int unsigned tx_calm = 0;
    int unsigned rx_run = 0;
    int unsigned rx_pause = 0;
    int unsigned rx_hold = 0;
    int unsigned rx_roll;
    bit          rx_hold_done = 1'b0;
    bit          res_some;
    result_t     res_now;
    result_t     res_due;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        $display("mismatch on %s: expected %h, got %h at %0t", what, want, got, $time);
    endtask

    // end of the feature pairs: either labels follow or the record closes with a done
    function automatic bit close_features(output result_t r);
        r = '0;
        if (label_left == 0) begin
            parse_ph = PH_HDR0;
            r.kind = KIND_DONE;
            r.bad = bad_flag;
            return 1'b1;
        end
        parse_ph = PH_LABELS;
        return 1'b0;
    endfunction

    function automatic bit parse_beat(input beat_t b, output result_t r);
        int unsigned eff;
        r = '0;
        if (b.mode == MODE_READ) begin
            r.kind = KIND_READ;
            r.slot = b.rslot;
            r.bad = bad_flag;
            r.value = slot_live[b.rslot] ? dense_mem[b.rslot] : '0;
            return 1'b1;
        end
        eff = (dim_reg > MAX_DIMENSION) ? MAX_DIMENSION : dim_reg;
        case (parse_ph)
            PH_HDR0: begin
                foreach (slot_live[i]) slot_live[i] = 1'b0;
                bad_flag = 1'b0;
                records_seen++;
                parse_ph = PH_HDR1;
            end
            PH_HDR1: parse_ph = PH_FCOUNT;
            PH_FCOUNT: begin
                feature_left = b.word;
                parse_ph = PH_LCOUNT;
            end
            PH_LCOUNT: begin
                label_left = b.word;
                pair_pos = POS_ID_LO;
                if (feature_left == 0)
                    return close_features(r);
                parse_ph = PH_PAIRS;
            end
            PH_PAIRS: begin
                case (pair_pos)
                    POS_ID_LO: begin
                        id_pending = b.word;
                        pair_pos = POS_ID_HI;
                    end
                    POS_ID_HI: pair_pos = POS_VALUE;
                    default: begin
                        pair_pos = POS_ID_LO;
                        if (id_pending < eff) begin
                            dense_mem[id_pending[ADDR_W-1:0]] = b.word;
                            slot_live[id_pending[ADDR_W-1:0]] = 1'b1;
                        end else begin
                            bad_flag = 1'b1;
                        end
                        feature_left = feature_left - 1;
                        if (feature_left == 0)
                            return close_features(r);
                    end
                endcase
            end
            PH_LABELS: begin
                label_left = label_left - 1;
                r.kind = KIND_LABEL;
                r.value = b.word;
                r.last = (label_left == 0);
                r.bad = bad_flag;
                if (label_left == 0)
                    parse_ph = PH_HDR0;
                return 1'b1;
            end
            default: parse_ph = PH_HDR0;
        endcase
        return 1'b0;
    endfunction

    function automatic beat_t rec_word(input logic [31:0] w);
        beat_t b;
        b.mode = MODE_WORD;
        b.word = w;
        b.rslot = SLOT_W'($urandom_range(0, MAX_DIMENSION - 1));
        b.fixed = 1'b0;
        b.fixed_res = '0;
        return b;
    endfunction

    function automatic beat_t slot_read(input logic [9:0] slot);
        beat_t b;
        b.mode = MODE_READ;
        b.word = $urandom;
        b.rslot = slot;
        b.fixed = 1'b0;
        b.fixed_res = '0;
        return b;
    endfunction

    function automatic beat_t expecting(input beat_t b, input logic [KIND_W-1:0] kind,
                                        input logic [31:0] value, input logic [9:0] slot,
                                        input logic last, input logic bad);
        b.fixed = 1'b1;
        b.fixed_res = '{kind: kind, value: value, slot: slot, last: last, bad: bad};
        return b;
    endfunction

    function automatic logic [9:0] pick_written();
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    function automatic void add_beat(input beat_t b);
        feed_q.insert(feed_q.size(), b);
    endfunction

    // reads only target slots that some record has already filled
    function automatic void push_word(input logic [31:0] w);
        if (written_list.size() != 0 && $urandom_range(0, 99) < 10)
            add_beat(slot_read(pick_written()));
        add_beat(rec_word(w));
    endfunction

    task automatic send_feed();
        int unsigned gap;
        int unsigned roll;
        foreach (feed_q[i]) begin
            if (tx_calm != 0) begin
                tx_calm--;
                gap = 0;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 2) tx_calm = $urandom_range(40, 120);
                if (roll < 55) gap = 0;
                else if (roll < 85) gap = $urandom_range(1, 3);
                else if (roll < 97) gap = $urandom_range(4, 12);
                else gap = $urandom_range(20, 60);
            end
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            beat_on_bus = feed_q[i];
            s_valid <= 1'b1;
            s_mode <= feed_q[i].mode;
            s_data_word <= feed_q[i].word;
            s_read_slot <= feed_q[i].rslot;
            do @(posedge aclk); while (!s_ready);
            @(negedge aclk);
        end
        s_valid <= 1'b0;
        feed_q.delete();
    endtask

    // receiver: short runs and pauses, rare long runs, one long hold to back up the block
    always @(negedge aclk) begin
        if (rx_hold == 0 && !rx_hold_done && results_checked >= RX_HOLD_AFTER) begin
            rx_hold_done = 1'b1;
            rx_hold = RX_HOLD_CYCLES;
        end
        if (rx_hold != 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else begin
            if (rx_run == 0 && rx_pause == 0) begin
                rx_roll = $urandom_range(0, 99);
                if (rx_roll < 65) rx_run = $urandom_range(1, 6);
                else if (rx_roll < 90) rx_pause = $urandom_range(1, 3);
                else if (rx_roll < 97) rx_pause = $urandom_range(5, 25);
                else rx_run = $urandom_range(60, 200);
            end
            if (rx_pause != 0) begin
                rx_pause--;
                m_ready <= 1'b0;
            end else begin
                rx_run--;
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            stall_cycles++;
            if (s_valid && s_ready) begin
                stall_cycles = 0;
                beats_taken++;
                if (beat_on_bus.mode == MODE_READ) slot_reads++;
                res_some = parse_beat(beat_on_bus, res_now);
                if (beat_on_bus.fixed)
                    results_due.insert(results_due.size(), beat_on_bus.fixed_res);
                else if (res_some)
                    results_due.insert(results_due.size(), res_now);
            end
            if (cfg_valid && cfg_ready) begin
                stall_cycles = 0;
                dim_reg = cfg_dense_dimension;
            end
            if (m_valid && m_ready) begin
                stall_cycles = 0;
                results_checked++;
                if (results_due.size() == 0) begin
                    report_mismatch("result beat with nothing due, kind", '0, 32'(m_kind));
                end else begin
                    res_due = results_due.pop_front();
                    if (m_kind != res_due.kind)
                        report_mismatch("kind", 32'(res_due.kind), 32'(m_kind));
                    if (m_value_bits != res_due.value)
                        report_mismatch("value_bits", res_due.value, m_value_bits);
                    if (m_slot != res_due.slot)
                        report_mismatch("slot", 32'(res_due.slot), 32'(m_slot));
                    if (m_last_label != res_due.last)
                        report_mismatch("last_label", 32'(res_due.last), 32'(m_last_label));
                    if (m_bad_id_seen != res_due.bad)
                        report_mismatch("bad_id_seen", 32'(res_due.bad), 32'(m_bad_id_seen));
                end
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", stall_cycles);
                $display("sparse_record_to_dense_parser verification failed");
                $finish;
            end
        end
    end

    initial begin
        logic [10:0] dim_plan [DIM_SETTINGS];
        int unsigned eff;
        int unsigned nf;
        int unsigned nl;
        int unsigned roll;
        int unsigned id;
        logic [9:0]  reuse;

        dim_plan = '{11'd1, 11'd0, 11'd2047, 11'd37, 11'd1024, 11'd600};

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // directed records at the reset dimension of 1024
        add_beat(rec_word(32'hFFFF_FFFF));
        add_beat(rec_word(32'h0000_0000));
        add_beat(rec_word(32'd3));
        add_beat(rec_word(32'd2));
        add_beat(rec_word(32'd0));
        add_beat(rec_word(32'hFFFF_FFFF));     // high id word is ignored
        add_beat(rec_word(32'h3F80_0000));
        add_beat(expecting(slot_read(10'd0), KIND_READ, 32'h3F80_0000, 10'd0, 1'b0, 1'b0));
        add_beat(rec_word(32'd1023));
        add_beat(rec_word(32'h1234_5678));
        add_beat(rec_word(32'hFFFF_FFFF));
        add_beat(rec_word(32'd1024));          // id equal to the dimension: dropped
        add_beat(rec_word(32'h0000_0000));
        add_beat(rec_word(32'hDEAD_BEEF));
        add_beat(expecting(rec_word(32'h4000_0000), KIND_LABEL, 32'h4000_0000,
                           10'd0, 1'b0, 1'b1));
        add_beat(expecting(rec_word(32'h0000_0000), KIND_LABEL, 32'h0, 10'd0, 1'b1, 1'b1));
        add_beat(expecting(slot_read(10'd1023), KIND_READ, 32'hFFFF_FFFF,
                           10'd1023, 1'b0, 1'b1));
        add_beat(rec_word(32'hA5A5_A5A5));
        add_beat(rec_word(32'h5A5A_5A5A));
        add_beat(rec_word(32'd0));
        add_beat(expecting(rec_word(32'd0), KIND_DONE, 32'h0, 10'd0, 1'b0, 1'b0));
        // new record start cleared every slot
        add_beat(expecting(slot_read(10'd0), KIND_READ, 32'h0, 10'd0, 1'b0, 1'b0));
        add_beat(expecting(slot_read(10'd1023), KIND_READ, 32'h0, 10'd1023, 1'b0, 1'b0));
        slot_written[0] = 1'b1;
        slot_written[1023] = 1'b1;
        written_list.insert(written_list.size(), 10'd0);
        written_list.insert(written_list.size(), 10'd1023);
        send_feed();

        foreach (dim_plan[p]) begin
            // reprogram only with the block drained
            while (results_due.size() != 0) @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);
            @(negedge aclk);
            cfg_valid <= 1'b1;
            cfg_dense_dimension <= dim_plan[p];
            do @(posedge aclk); while (!cfg_ready);
            @(negedge aclk);
            cfg_valid <= 1'b0;
            settings_used++;

            eff = (dim_plan[p] > MAX_DIMENSION) ? MAX_DIMENSION : dim_plan[p];
            while (feed_q.size() < RANDOM_BEATS / DIM_SETTINGS) begin
                roll = $urandom_range(0, 99);
                if (roll < 5) begin
                    // bare slot reads between records
                    repeat ($urandom_range(1, 3))
                        add_beat(slot_read(pick_written()));
                    continue;
                end
                roll = $urandom_range(0, 99);
                if (roll < 35) nf = 0;
                else if (roll < 85) nf = $urandom_range(1, 4);
                else nf = $urandom_range(5, 12);
                nl = ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 4);
                push_word($urandom);
                push_word($urandom);
                push_word(nf);
                push_word(nl);
                repeat (nf) begin
                    roll = $urandom_range(0, 99);
                    reuse = pick_written();
                    if (eff == 0 || roll < 12)
                        id = (roll < 6) ? eff + $urandom_range(0, 3) : $urandom;
                    else if (roll < 25 && reuse < eff)
                        id = reuse;
                    else
                        id = $urandom_range(0, eff - 1);
                    push_word(id);
                    push_word($urandom);
                    push_word($urandom);
                    if (id < eff && !slot_written[id]) begin
                        slot_written[id] = 1'b1;
                        written_list.insert(written_list.size(), id[9:0]);
                    end
                end
                repeat (nl) push_word($urandom);
            end
            send_feed();
        end

        while (results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d beats over %0d records, %0d of them slot reads",
                 beats_taken, records_seen, slot_reads);
        $display("%0d results checked across %0d dimension settings, %0d mismatches",
                 results_checked, settings_used, mismatches);
        if (mismatches == 0)
            $display("sparse_record_to_dense_parser verification clean");
        else
            $display("sparse_record_to_dense_parser verification failed");
        $finish;
    end

endmodule

[files.f]
sv/srdp_pkg.sv
sv/srdp_front.sv
sv/srdp_cmd_fifo.sv
sv/srdp_back.sv
sv/sparse_record_to_dense_parser.sv
dv/sparse_record_to_dense_parser_tb.sv
